@@ sv/prms_pkg.sv @@
package prms_pkg;

    localparam int RATE_W = 18;
    localparam int FMT_W = 2;
    localparam int SAMPLE_W = 16;
    localparam int FRAMES_W = 13;
    localparam int ACC_W = 20;
    localparam int SUM_W = ACC_W + 1;
    localparam int PROD_W = FRAMES_W + RATE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [FRAMES_W-1:0] MAX_CHUNK_FRAMES = 13'd4096;
    localparam logic [ACC_W-1:0] ACC_MAX = 20'd524287;

    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FMT = 2'd3;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd22050;
    localparam logic [FMT_W-1:0] FMT_RESET = 2'd3;

    localparam int FMT_WIDE_BIT = 0;
    localparam int FMT_STEREO_BIT = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_SUB,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ sv/prms_in_if.sv @@
interface prms_in_if;
    import prms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  start_req;
    logic [SAMPLE_W-1:0]   src_left_raw;
    logic [SAMPLE_W-1:0]   src_right_raw;
    logic [FRAMES_W-1:0]   src_frames_left;
    logic [SAMPLE_W-1:0]   dest_left_raw;
    logic [SAMPLE_W-1:0]   dest_right_raw;

    modport source (
        output valid, start_req, src_left_raw, src_right_raw, src_frames_left,
               dest_left_raw, dest_right_raw,
        input  ready
    );

    modport sink (
        input  valid, start_req, src_left_raw, src_right_raw, src_frames_left,
               dest_left_raw, dest_right_raw,
        output ready
    );

endinterface

@@ sv/prms_out_if.sv @@
interface prms_out_if;
    import prms_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SAMPLE_W-1:0]   mixed_left_raw;
    logic [SAMPLE_W-1:0]   mixed_right_raw;
    logic [FRAMES_W-1:0]   src_advance;

    modport source (
        output valid, mixed_left_raw, mixed_right_raw, src_advance,
        input  ready
    );

    modport sink (
        input  valid, mixed_left_raw, mixed_right_raw, src_advance,
        output ready
    );

endinterface

@@ sv/prms_div.sv @@
module prms_div
    import prms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [ACC_W-1:0]     i_dividend,
    input  logic [RATE_W-1:0]    i_divisor,
    output t_div_sts             o_sts,
    output logic [ACC_W-1:0]     o_quotient,
    output logic [RATE_W-1:0]    o_remainder
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [RATE_W-1:0]     r_rem;
    logic [ACC_W-1:0]      r_quo;
    logic [RATE_W-1:0]     r_dvs;

    logic [RATE_W:0]       w_trial;
    logic [RATE_W+1:0]     w_diff;
    logic                  w_fits;

    assign w_trial = {r_rem, r_quo[ACC_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
    assign w_fits  = ~w_diff[RATE_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            r_quo <= {r_quo[ACC_W-2:0], w_fits};
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ sv/prms_mix.sv @@
module prms_mix
    import prms_pkg::*;
(
    input  logic [SAMPLE_W-1:0]         i_dest,
    input  logic signed [SAMPLE_W-1:0]  i_held,
    input  logic                        i_wide,
    output logic [SAMPLE_W-1:0]         o_mix
);

    logic signed [SAMPLE_W:0]  w_sum16;
    logic signed [9:0]         w_sum8;

    assign w_sum16 = $signed({i_dest[SAMPLE_W-1], i_dest}) + $signed({i_held[SAMPLE_W-1], i_held});
    assign w_sum8  = $signed({2'b00, i_dest[7:0]})
                   + $signed({{2{i_held[SAMPLE_W-1]}}, i_held[SAMPLE_W-1:8]});

    always_comb begin
        if (i_wide) begin
            if (w_sum16 > 17'sd32767) begin
                o_mix = 16'h7FFF;
            end else if (w_sum16 < -17'sd32768) begin
                o_mix = 16'h8000;
            end else begin
                o_mix = w_sum16[SAMPLE_W-1:0];
            end
        end else begin
            if (w_sum8 > 10'sd255) begin
                o_mix = 16'h00FF;
            end else if (w_sum8 < 10'sd0) begin
                o_mix = 16'h0000;
            end else begin
                o_mix = {8'h00, w_sum8[7:0]};
            end
        end
    end

endmodule

@@ sv/pcm_resample_mix_saturate.sv @@
// Sample-and-hold resampler with saturating mix. Each input transfer is one destination
// frame; each output transfer carries the mixed frame and the number of source frames to
// skip. When the rate accumulator reaches dst_rate the source frame is latched, converted
// and folded to mono if needed, and a 20-step shift-subtract divider works out the skip
// count. A frame that latches nothing goes from the check state straight to finish; one
// that latches a source frame spends most of its time in the divider, then passes through
// a multiply and a subtract state if the quotient exceeds the frames left. Input is not
// ready while a frame is in work, but a finished result may wait in the output register
// while the next frame is taken. Configuration writes belong to idle periods only.
module pcm_resample_mix_saturate
    import prms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [RATE_W-1:0]      i_cfg_data,
    prms_in_if.sink                i_src,
    prms_out_if.source             o_res
);

    function automatic logic signed [SAMPLE_W-1:0] f_decode(input logic [SAMPLE_W-1:0] raw,
                                                          input logic wide);
        if (wide) begin
            return raw;
        end
        return {~raw[7], raw[6:0], 8'h00};
    endfunction

    t_state r_state, n_state;

    logic [RATE_W-1:0]           r_src_rate, r_dst_rate;
    logic [FMT_W-1:0]            r_src_fmt, r_dst_fmt;

    logic signed [ACC_W-1:0]     r_accum;
    logic signed [SAMPLE_W-1:0]  r_held_l, r_held_r;

    logic signed [SUM_W-1:0]     r_acc;
    logic [FRAMES_W-1:0]         r_frames;
    logic [SAMPLE_W-1:0]         r_src_l, r_src_r, r_dest_l, r_dest_r;
    logic [FRAMES_W-1:0]         r_k;
    logic                        r_bypass;
    logic [PROD_W-1:0]           r_prod;

    logic                        r_out_valid;
    logic [SAMPLE_W-1:0]         r_out_l, r_out_r;
    logic [FRAMES_W-1:0]         r_out_adv;

    logic [RATE_W-1:0]           w_sr, w_dr;
    logic                        w_s16, w_sst, w_d16, w_dst;
    logic                        w_in_acc, w_in_ready, w_div_start, w_out_load;
    logic                        w_hit, w_no_frames, w_clamp;
    logic signed [ACC_W-1:0]     w_base;
    logic [FRAMES_W-1:0]         w_frames_in;
    logic signed [SAMPLE_W-1:0]  w_dec_l, w_dec_r, w_fold_l;
    logic signed [SAMPLE_W:0]    w_pair;
    logic [PROD_W-1:0]           w_diff;
    logic [SAMPLE_W-1:0]         w_mix_l, w_mix_r, w_res_l, w_res_r;
    t_div_sts                    w_div_sts;
    logic [ACC_W-1:0]            w_quo;
    logic [RATE_W-1:0]           w_rem;

    assign w_sr  = (r_src_rate == '0) ? RATE_W'(1) : r_src_rate;
    assign w_dr  = (r_dst_rate == '0) ? RATE_W'(1) : r_dst_rate;
    assign w_s16 = r_src_fmt[FMT_WIDE_BIT];
    assign w_sst = r_src_fmt[FMT_STEREO_BIT];
    assign w_d16 = r_dst_fmt[FMT_WIDE_BIT];
    assign w_dst = r_dst_fmt[FMT_STEREO_BIT];

    assign w_in_acc = i_src.valid && w_in_ready;

    assign w_base = i_src.start_req ? ($signed({2'b00, w_dr}) - $signed({2'b00, w_sr}))
                                    : r_accum;
    assign w_frames_in = (i_src.src_frames_left > MAX_CHUNK_FRAMES) ? MAX_CHUNK_FRAMES
                                                                   : i_src.src_frames_left;

    assign w_hit       = r_acc >= $signed({3'b000, w_dr});
    assign w_no_frames = (r_frames == '0);
    assign w_clamp     = w_quo > {{(ACC_W-FRAMES_W){1'b0}}, r_frames};

    assign w_dec_l  = f_decode(r_src_l, w_s16);
    assign w_dec_r  = w_sst ? f_decode(r_src_r, w_s16) : w_dec_l;
    assign w_pair   = $signed({w_dec_l[SAMPLE_W-1], w_dec_l})
                    + $signed({w_dec_r[SAMPLE_W-1], w_dec_r});
    assign w_fold_l = w_dst ? w_dec_l : w_pair[SAMPLE_W:1];

    assign w_diff = PROD_W'(unsigned'(r_acc)) - r_prod;

    prms_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_acc[ACC_W-1:0]),
        .i_divisor   (w_dr),
        .o_sts       (w_div_sts),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    prms_mix u_mix_l (
        .i_dest (r_dest_l),
        .i_held (r_held_l),
        .i_wide (w_d16),
        .o_mix  (w_mix_l)
    );

    prms_mix u_mix_r (
        .i_dest (r_dest_r),
        .i_held (r_held_r),
        .i_wide (w_d16),
        .o_mix  (w_mix_r)
    );

    always_comb begin
        if (r_bypass) begin
            w_res_l = w_d16 ? r_dest_l : {8'h00, r_dest_l[7:0]};
            w_res_r = (w_dst && !w_d16) ? {8'h00, r_dest_r[7:0]} : r_dest_r;
        end else begin
            w_res_l = w_mix_l;
            w_res_r = w_dst ? w_mix_r : r_dest_r;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_div_start) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (w_div_sts.done) begin
                    n_state = w_clamp ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL: begin
                n_state = ST_SUB;
            end
            ST_SUB: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_CHECK: begin
                w_div_start = !w_no_frames && w_hit;
            end
            ST_FIN: begin
                w_out_load = !r_out_valid || o_res.ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_src_rate  <= RATE_RESET;
            r_dst_rate  <= RATE_RESET;
            r_src_fmt   <= FMT_RESET;
            r_dst_fmt   <= FMT_RESET;
            r_accum     <= '0;
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SRC_RATE: r_src_rate <= i_cfg_data;
                    CFG_DST_RATE: r_dst_rate <= i_cfg_data;
                    CFG_SRC_FMT:  r_src_fmt  <= i_cfg_data[FMT_W-1:0];
                    CFG_DST_FMT:  r_dst_fmt  <= i_cfg_data[FMT_W-1:0];
                    default:      r_src_rate <= r_src_rate;
                endcase
            end

            if (w_in_acc) begin
                r_accum <= w_base;
            end

            if (r_state == ST_CHECK && !w_no_frames) begin
                if (w_hit) begin
                    r_held_l <= w_fold_l;
                    r_held_r <= w_dec_r;
                end else begin
                    r_accum <= r_acc[ACC_W-1:0];
                end
            end

            if (r_state == ST_DIV && w_div_sts.done && !w_clamp) begin
                r_accum <= {{(ACC_W-RATE_W){1'b0}}, w_rem};
            end

            if (r_state == ST_SUB) begin
                r_accum <= (w_diff[SUM_W-1:0] > {1'b0, ACC_MAX}) ? ACC_MAX
                                                                 : w_diff[ACC_W-1:0];
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_acc    <= $signed({w_base[ACC_W-1], w_base}) + $signed({3'b000, w_sr});
            r_frames <= w_frames_in;
            r_src_l  <= i_src.src_left_raw;
            r_src_r  <= i_src.src_right_raw;
            r_dest_l <= i_src.dest_left_raw;
            r_dest_r <= i_src.dest_right_raw;
        end
        if (r_state == ST_CHECK) begin
            r_bypass <= w_no_frames;
            r_k      <= '0;
        end
        if (r_state == ST_DIV && w_div_sts.done) begin
            r_k <= w_clamp ? r_frames : w_quo[FRAMES_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_frames) * PROD_W'(w_dr);
        end
        if (w_out_load) begin
            r_out_l   <= w_res_l;
            r_out_r   <= w_res_r;
            r_out_adv <= r_k;
        end
    end

    assign i_src.ready           = w_in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.mixed_left_raw  = r_out_l;
    assign o_res.mixed_right_raw = r_out_r;
    assign o_res.src_advance     = r_out_adv;

endmodule

@@ sv/prms_checker.sv @@
module prms_checker
    import prms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [SAMPLE_W-1:0]   i_out_left,
    input  logic [SAMPLE_W-1:0]   i_out_right,
    input  logic [FRAMES_W-1:0]   i_out_adv
);

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready while a frame is in work");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after transfer in");

    a_skip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_adv <= MAX_CHUNK_FRAMES))
        else $error("skip count beyond chunk bound");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_left)
            && $stable(i_out_right) && $stable(i_out_adv)))
        else $error("stalled result changed");

endmodule

bind pcm_resample_mix_saturate prms_checker u_prms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_src.valid),
    .i_in_ready  (i_src.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_left  (o_res.mixed_left_raw),
    .i_out_right (o_res.mixed_right_raw),
    .i_out_adv   (o_res.src_advance)
);
